// File: sv/spiral_scan_next_cell_macros.svh
// Assertion macros for the spiral scan next-cell block.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef SPIRAL_SCAN_NEXT_CELL_MACROS_SVH
`define SPIRAL_SCAN_NEXT_CELL_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SSN_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SSN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/ssn_pkg.sv
// Package of the spiral scan next-cell block: payload types, heading codes,
// register indexes and the stage records passed between the modules.
`default_nettype none

package ssn_pkg;

  localparam int unsigned GRID_SIDE = 64;
  localparam int unsigned CoordW    = $clog2(GRID_SIDE);  // row / column index
  localparam int unsigned MarginW   = CoordW + 1;         // margin counts
  localparam int unsigned OutCoordW = CoordW + 2;         // signed next cell
  localparam int unsigned WorkW     = MarginW + 3;        // signed work width
  localparam int unsigned HeadW     = 3;

  localparam logic [HeadW-1:0] HEAD_NONE  = 3'd0;
  localparam logic [HeadW-1:0] HEAD_RIGHT = 3'd1;
  localparam logic [HeadW-1:0] HEAD_DOWN  = 3'd2;
  localparam logic [HeadW-1:0] HEAD_LEFT  = 3'd3;
  localparam logic [HeadW-1:0] HEAD_UP    = 3'd4;

  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_LAST_COLUMN = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_LAST_ROW    = 1'd1;

  typedef struct packed {
    logic [CoordW-1:0]  cur_row;
    logic [CoordW-1:0]  cur_column;
    logic [MarginW-1:0] top_margin;
    logic [MarginW-1:0] bottom_margin;
    logic [MarginW-1:0] left_margin;
    logic [MarginW-1:0] right_margin;
    logic [HeadW-1:0]   heading;
  } ssn_in_t;

  typedef struct packed {
    logic signed [OutCoordW-1:0] next_row;
    logic signed [OutCoordW-1:0] next_column;
    logic [MarginW-1:0]          next_top_margin;
    logic [MarginW-1:0]          next_bottom_margin;
    logic [MarginW-1:0]          next_left_margin;
    logic [MarginW-1:0]          next_right_margin;
    logic [HeadW-1:0]            next_heading;
    logic                        side_end;
    logic                        outside;
  } ssn_out_t;

  // Stage 1 record: the request plus the live-area bounds.
  typedef struct packed {
    ssn_in_t                 req;
    logic signed [WorkW-1:0] top;
    logic signed [WorkW-1:0] bottom;
    logic signed [WorkW-1:0] left;
    logic signed [WorkW-1:0] right;
    logic                    early_out;
  } ssn_bounds_t;

  // Stage 2 record: the moved cursor with margins kept one bit wider.
  typedef struct packed {
    logic signed [WorkW-1:0] nr;
    logic signed [WorkW-1:0] nc;
    logic [MarginW:0]        nt;
    logic [MarginW:0]        nb;
    logic [MarginW:0]        nl;
    logic [MarginW:0]        nrm;
    logic [HeadW-1:0]        nh;
    logic                    side_end;
    logic                    early_out;
  } ssn_move_t;

endpackage

`default_nettype wire

// File: sv/ssn_if.sv
// Valid/ready channel carrying one spiral cursor request or result.
// Depends on ssn_pkg for the payload types.
`default_nettype none

interface ssn_in_if;
  import ssn_pkg::*;
  logic    valid;
  logic    ready;
  ssn_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ssn_out_if;
  import ssn_pkg::*;
  logic     valid;
  logic     ready;
  ssn_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: sv/spiral_scan_next_cell.sv
// Spiral scan next-cell generator: a three-stage pipeline that turns one
// spiral cursor request into the next cell of a clockwise inward spiral.
// Depends on ssn_pkg, ssn_if, ssn_move and spiral_scan_next_cell_macros.svh.
//
// Each request gives the next cell of a clockwise inward spiral over a grid
// of (last_row+1) x (last_column+1) cells. The block takes one request every
// clock while input ready is high and returns exactly one result per request,
// in order. A request passes the three register stages: live-area bounds,
// cursor step and turn, then the finished check. Every stage holds under a
// stall and a stage frees as soon as its contents move on, so ready on the
// input drops only when all three stages are full and the output is stalled.
// The result register is the last stage, so a finished result waiting on the
// output never blocks a request behind a bubble. The grid size registers are
// written through cfg_we_i, cfg_idx_i (0 last_column, 1 last_row) and
// cfg_wdata_i; the user must write them only while no request is in flight,
// which the block does not enforce. Both reset to the full 64 x 64 grid.
`default_nettype none

module spiral_scan_next_cell (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         cfg_we_i,
  input  wire [ssn_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire [ssn_pkg::CoordW-1:0]   cfg_wdata_i,
  ssn_in_if.sink                      in_req_i,
  ssn_out_if.source                   out_rsp_o
);
  import ssn_pkg::*;

  `include "spiral_scan_next_cell_macros.svh"

  // Grid size registers
  logic [CoordW-1:0] last_column_q;
  logic [CoordW-1:0] last_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_column_q <= CoordW'(GRID_SIDE - 1);
      last_row_q    <= CoordW'(GRID_SIDE - 1);
    end else if (cfg_we_i) begin
      // The register width spans the whole grid, so no clamp is needed.
      case (cfg_idx_i)
        CFG_LAST_COLUMN: last_column_q <= cfg_wdata_i;
        CFG_LAST_ROW:    last_row_q    <= cfg_wdata_i;
        default:         ;
      endcase
    end
  end

  // Stall chain: a stage takes new data when it is empty or drains.
  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  assign rdy3 = !v3_q || out_rsp_o.ready;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_req_i.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_req_i.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // Stage 1: live-area bounds, crossed bounds and unknown heading.
  ssn_bounds_t s1_d, s1_q;
  logic        bad_head;

  always_comb begin
    s1_d.req    = in_req_i.data;
    s1_d.top    = $signed(WorkW'(in_req_i.data.top_margin));
    s1_d.left   = $signed(WorkW'(in_req_i.data.left_margin));
    s1_d.bottom = $signed(WorkW'(last_row_q)) -
                  $signed(WorkW'(in_req_i.data.bottom_margin));
    s1_d.right  = $signed(WorkW'(last_column_q)) -
                  $signed(WorkW'(in_req_i.data.right_margin));
    bad_head    = !(in_req_i.data.heading inside {[HEAD_RIGHT:HEAD_UP]});
    s1_d.early_out = bad_head || (s1_d.top > s1_d.bottom) ||
                     (s1_d.left > s1_d.right);
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_req_i.valid) s1_q <= s1_d;
  end

  // Stage 2: step along the side, turn at its end.
  ssn_move_t s2_d, s2_q;

  ssn_move u_move (
    .b_i (s1_q),
    .m_o (s2_d)
  );

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) s2_q <= s2_d;
  end

  // Stage 3: finished check on the moved margins, trim to result widths.
  ssn_out_t         s3_d, s3_q;
  logic [MarginW+1:0] sum_rows, sum_cols;

  always_comb begin
    sum_rows = {1'b0, s2_q.nt} + {1'b0, s2_q.nb};
    sum_cols = {1'b0, s2_q.nl} + {1'b0, s2_q.nrm};
    s3_d.next_row           = s2_q.nr[OutCoordW-1:0];
    s3_d.next_column        = s2_q.nc[OutCoordW-1:0];
    s3_d.next_top_margin    = s2_q.nt[MarginW-1:0];
    s3_d.next_bottom_margin = s2_q.nb[MarginW-1:0];
    s3_d.next_left_margin   = s2_q.nl[MarginW-1:0];
    s3_d.next_right_margin  = s2_q.nrm[MarginW-1:0];
    s3_d.next_heading       = s2_q.nh;
    s3_d.side_end           = s2_q.side_end;
    s3_d.outside            = s2_q.early_out ||
                              (sum_rows > (MarginW+2)'(last_row_q)) ||
                              (sum_cols > (MarginW+2)'(last_column_q));
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) s3_q <= s3_d;
  end

  assign out_rsp_o.valid = v3_q;
  assign out_rsp_o.data  = s3_q;

  // Checks
  `SSN_ASSERT_NOW(a_ready_only_when_full, !in_req_i.ready,
    v1_q && v2_q && v3_q && !out_rsp_o.ready, "input stalled with a free stage")
  `SSN_ASSERT_NOW(a_none_heading_outside,
    out_rsp_o.valid && (out_rsp_o.data.next_heading == HEAD_NONE),
    out_rsp_o.data.outside && !out_rsp_o.data.side_end,
    "heading none gave a move")
  `SSN_ASSERT_NEXT(a_stage2_held, v2_q && !rdy2, v2_q && $stable(s2_q),
    "stalled stage 2 lost its item")

endmodule

`default_nettype wire

// File: sv/ssn_move.sv
// Move logic of the spiral scan: steps the cursor along its side and turns
// at the side's end. Depends on ssn_pkg.
`default_nettype none

module ssn_move (
  input  wire ssn_pkg::ssn_bounds_t b_i,
  output ssn_pkg::ssn_move_t        m_o
);
  import ssn_pkg::*;

  // One cell step at the signed work width
  localparam logic signed [WorkW-1:0] StepOne = WorkW'(1);

  logic signed [WorkW-1:0] row_s;
  logic signed [WorkW-1:0] col_s;
  logic [MarginW:0]        mt, mb, ml, mr;

  assign row_s = $signed({{(WorkW-CoordW){1'b0}}, b_i.req.cur_row});
  assign col_s = $signed({{(WorkW-CoordW){1'b0}}, b_i.req.cur_column});
  assign mt    = {1'b0, b_i.req.top_margin};
  assign mb    = {1'b0, b_i.req.bottom_margin};
  assign ml    = {1'b0, b_i.req.left_margin};
  assign mr    = {1'b0, b_i.req.right_margin};

  always_comb begin
    m_o.nr        = row_s;
    m_o.nc        = col_s;
    m_o.nt        = mt;
    m_o.nb        = mb;
    m_o.nl        = ml;
    m_o.nrm       = mr;
    m_o.nh        = b_i.req.heading;
    m_o.side_end  = 1'b0;
    m_o.early_out = b_i.early_out;
    if (!b_i.early_out) begin
      case (b_i.req.heading)
        HEAD_RIGHT: begin
          m_o.nr = b_i.top;
          m_o.nc = col_s + StepOne;
          if (col_s + StepOne > b_i.right) begin
            m_o.nt       = mt + 1'b1;
            m_o.nh       = HEAD_DOWN;
            m_o.nc       = b_i.right;
            m_o.nr       = b_i.top + StepOne;
            m_o.side_end = 1'b1;
          end
        end
        HEAD_DOWN: begin
          m_o.nc = b_i.right;
          m_o.nr = row_s + StepOne;
          if (row_s + StepOne > b_i.bottom) begin
            m_o.nrm      = mr + 1'b1;
            m_o.nh       = HEAD_LEFT;
            m_o.nr       = b_i.bottom;
            m_o.nc       = b_i.right - StepOne;
            m_o.side_end = 1'b1;
          end
        end
        HEAD_LEFT: begin
          m_o.nr = b_i.bottom;
          m_o.nc = col_s - StepOne;
          if (col_s - StepOne < b_i.left) begin
            m_o.nb       = mb + 1'b1;
            m_o.nh       = HEAD_UP;
            m_o.nc       = b_i.left;
            m_o.nr       = b_i.bottom - StepOne;
            m_o.side_end = 1'b1;
          end
        end
        default: begin
          // up
          m_o.nc = b_i.left;
          m_o.nr = row_s - StepOne;
          if (row_s - StepOne < b_i.top) begin
            m_o.nl       = ml + 1'b1;
            m_o.nh       = HEAD_RIGHT;
            m_o.nr       = b_i.top;
            m_o.nc       = b_i.left + StepOne;
            m_o.side_end = 1'b1;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire
